[sv/uvr_pkg.sv]
// Shared types, constants and helper functions for the UV triangle rasterizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package uvr_pkg;

  localparam int XW       = 7;              // column index bits
  localparam int YW       = 7;              // row index bits
  localparam int TEX_W    = 1 << XW;
  localparam int TEX_H    = 1 << YW;
  localparam int NPIX     = TEX_W * TEX_H;
  localparam int AW       = XW + YW;        // pixel address bits
  localparam int PASS_CAP = 32;
  localparam int DW       = 21;             // vertex difference width
  localparam int PW       = 2 * DW;         // product width
  localparam int EW       = 44;             // edge value width
  localparam int QDEPTH   = 2;
  localparam int QAW      = 1;

  localparam logic [1:0] REG_CLEAR_VALUE    = 2'd0;
  localparam logic [1:0] REG_PADDING_PASSES = 2'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_PAINT  = 2'd1,
    CMD_DILATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [19:0] vert_a_u;
    logic signed [19:0] vert_a_v;
    logic signed [19:0] vert_b_u;
    logic signed [19:0] vert_b_v;
    logic signed [19:0] vert_c_u;
    logic signed [19:0] vert_c_v;
    logic [31:0]        part_word;
    logic [13:0]        pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [14:0] painted_count;
    logic [5:0]  passes_run;
    logic [31:0] pixel_value;
    logic        pixel_marked;
  } out_item_t;

  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [DW-1:0] diff_t;

  // decoded command handed from the front end to the engine
  typedef struct packed {
    cmd_t             cmd;
    logic [XW-1:0]    x0;
    logic [XW-1:0]    x1;
    logic [YW-1:0]    y0;
    logic [YW-1:0]    y1;
    logic [XW-1:0]    cx;
    logic [YW-1:0]    cy;
    edge_t [2:0]      e0;
    diff_t [2:0]      du;
    diff_t [2:0]      dv;
    logic [31:0]      word;
    logic [AW-1:0]    pix;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SETUP,
    F_OFS,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    B_INIT,
    B_IDLE,
    B_CLR,
    B_P_RD,
    B_P_LD,
    B_P_PIX,
    B_P_WB,
    B_P_CHK,
    B_C_LD,
    B_D_START,
    B_D_LC,
    B_D_RD,
    B_D_LD,
    B_D_PIX,
    B_D_WB,
    B_D_END,
    B_R_RD,
    B_R_LD,
    B_DONE
  } back_state_t;

  // floor(uv * size) arrives as a shifted value; clamp it into the texture
  function automatic logic [XW-1:0] clamp_px(input logic signed [10:0] v);
    logic [XW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(11'(TEX_W - 1))) begin
      r = XW'(TEX_W - 1);
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

  // floor(t / 3) clamped to the texture; t*171 >> 9 is exact below 3*TEX_W
  function automatic logic [XW-1:0] div3_clamp(input logic signed [12:0] t);
    logic [16:0]   p;
    logic [XW-1:0] r;
    p = 17'(t[8:0]) * 17'd171;
    if (t < 0) begin
      r = '0;
    end else if (t >= $signed(13'(3 * TEX_W))) begin
      r = XW'(TEX_W - 1);
    end else begin
      r = p[15:9];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/uvr_front.sv]
// Front end: accepts items, computes the clamped box, centroid and edge start values.
// Depends on uvr_pkg.
`default_nettype none

module uvr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire uvr_pkg::in_item_t in_item,
  input  wire logic            hold,
  output logic                 push,
  output uvr_pkg::op_t         push_op,
  input  wire logic            full
);
  import uvr_pkg::*;

  front_state_t state, state_next;
  in_item_t     item;
  op_t          o;
  diff_t        ex [3];
  diff_t        ey [3];
  logic signed [PW-1:0] prod;
  logic [2:0]   step;

  logic signed [19:0] uu [3];
  logic signed [19:0] vv [3];
  logic signed [19:0] ru [3];
  logic signed [19:0] rv [3];
  logic signed [19:0] umin, umax, vmin, vmax;
  logic signed [21:0] su, sv;
  diff_t        du_c [3];
  diff_t        dv_c [3];
  logic [1:0]   me, mi, pe;
  logic [2:0]   ps;
  diff_t        mul_a, mul_b;

  function automatic logic signed [19:0] min3(input logic signed [19:0] a,
                                              input logic signed [19:0] b,
                                              input logic signed [19:0] c);
    logic signed [19:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  function automatic logic signed [19:0] max3(input logic signed [19:0] a,
                                              input logic signed [19:0] b,
                                              input logic signed [19:0] c);
    logic signed [19:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  always_comb begin
    uu[0] = item.vert_a_u; uu[1] = item.vert_b_u; uu[2] = item.vert_c_u;
    vv[0] = item.vert_a_v; vv[1] = item.vert_b_v; vv[2] = item.vert_c_v;
    // edge e runs from vertex e to the next one
    ru[0] = uu[1]; ru[1] = uu[2]; ru[2] = uu[0];
    rv[0] = vv[1]; rv[1] = vv[2]; rv[2] = vv[0];
    umin = min3(uu[0], uu[1], uu[2]);
    umax = max3(uu[0], uu[1], uu[2]);
    vmin = min3(vv[0], vv[1], vv[2]);
    vmax = max3(vv[0], vv[1], vv[2]);
    su = $signed({{2{uu[0][19]}}, uu[0]}) + $signed({{2{uu[1][19]}}, uu[1]})
       + $signed({{2{uu[2][19]}}, uu[2]});
    sv = $signed({{2{vv[0][19]}}, vv[0]}) + $signed({{2{vv[1][19]}}, vv[1]})
       + $signed({{2{vv[2][19]}}, vv[2]});
    for (int e = 0; e < 3; e++) begin
      du_c[e] = $signed({uu[e][19], uu[e]}) - $signed({ru[e][19], ru[e]});
      dv_c[e] = $signed({vv[e][19], vv[e]}) - $signed({rv[e][19], rv[e]});
    end
  end

  // shared multiplier: even steps ex*dv, odd steps du*ey
  always_comb begin
    me    = step[2:1];
    mi    = (me == 2'd3) ? 2'd0 : me;
    ps    = step - 3'd1;
    pe    = ps[2:1];
    mul_a = step[0] ? $signed(o.du[mi]) : ex[mi];
    mul_b = step[0] ? ey[mi] : $signed(o.dv[mi]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid && in_ready) item <= in_item;
      end
      F_SETUP: begin
        o.cmd  <= item.cmd;
        o.word <= item.part_word;
        o.pix  <= item.pixel_index;
        o.x0   <= clamp_px($signed(umin[19:9]));
        o.x1   <= clamp_px($signed(umax[19:9]));
        o.y0   <= clamp_px($signed(vmin[19:9]));
        o.y1   <= clamp_px($signed(vmax[19:9]));
        o.cx   <= div3_clamp($signed(su[21:9]));
        o.cy   <= div3_clamp($signed(sv[21:9]));
        for (int e = 0; e < 3; e++) begin
          o.du[e] <= du_c[e];
          o.dv[e] <= dv_c[e];
        end
        step <= '0;
      end
      F_OFS: begin
        // sample center offset from the edge's end vertex, in units of 2^-16
        for (int e = 0; e < 3; e++) begin
          ex[e] <= $signed({{(DW-XW-9){1'b0}}, o.x0, 1'b1, 8'h00})
                 - $signed({ru[e][19], ru[e]});
          ey[e] <= $signed({{(DW-YW-9){1'b0}}, o.y0, 1'b1, 8'h00})
                 - $signed({rv[e][19], rv[e]});
        end
      end
      F_MUL: begin
        step <= step + 3'd1;
        prod <= mul_a * mul_b;
        for (int i = 0; i < 3; i++) begin
          if (step != 3'd0 && pe == 2'(i)) begin
            if (!ps[0]) begin
              o.e0[i] <= EW'(prod);
            end else begin
              o.e0[i] <= $signed(o.e0[i]) - $signed(EW'(prod));
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (in_valid && in_ready) state_next = F_SETUP;
      F_SETUP: state_next = (item.cmd == CMD_PAINT) ? F_OFS : F_PUSH;
      F_OFS:   state_next = F_MUL;
      F_MUL:   if (step == 3'd6) state_next = F_PUSH;
      F_PUSH:  if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == F_IDLE) && !hold;
    push     = (state == F_PUSH) && !full;
    push_op  = o;
  end

endmodule

`default_nettype wire

[sv/uvr_queue.sv]
// Two-entry queue of decoded commands between the front end and the engine.
// Depends on uvr_pkg.
`default_nettype none

module uvr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire uvr_pkg::op_t  din,
  input  wire logic          pop,
  output uvr_pkg::op_t       dout,
  output uvr_pkg::q_stat_t   stat
);
  import uvr_pkg::*;

  op_t            mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    dout       = mem[rp];
    stat.full  = (cnt == (QAW+1)'(QDEPTH));
    stat.empty = (cnt == '0);
  end

endmodule

`default_nettype wire

[sv/uvr_back.sv]
// Engine: pixel store, row-wide painted mask, config registers and result register.
// Runs clear, paint walk, dilation passes and reads. Depends on uvr_pkg.
`default_nettype none

module uvr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire uvr_pkg::op_t    op,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 init_busy,
  input  wire logic            cfg_valid,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [31:0]     cfg_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output uvr_pkg::out_item_t   out_item
);
  import uvr_pkg::*;

  back_state_t state, state_next;

  logic [31:0]      store [NPIX];
  logic [TEX_W-1:0] mask  [TEX_H];

  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [31:0]      st_wdata, st_rdata;
  logic             mk_we;
  logic [YW-1:0]    mk_waddr, mk_raddr;
  logic [TEX_W-1:0] mk_wdata, mk_rdata;

  logic [31:0]      clear_value;
  logic [5:0]       padding_passes;
  logic [5:0]       limit;

  op_t              cop;
  logic [AW-1:0]    cnt;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  edge_t            e [3];
  edge_t            erow [3];
  edge_t            sx [3];
  edge_t            sy [3];
  logic [14:0]      count;
  logic [5:0]       run;
  logic             changed;
  logic [TEX_W-1:0] prev, cur, nxt, fresh;
  logic             dpend;
  logic [AW-1:0]    dpend_addr;
  out_item_t        res;

  logic             neg, pos, cov;
  logic             lb, rb, dfill;
  logic [XW-1:0]    xl, xr;
  logic [YW-1:0]    ym, yp;
  logic [7:0]       cand;
  logic [AW-1:0]    nb_addr [8];
  logic [AW-1:0]    naddr;

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    st_rdata <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mask[mk_waddr] <= mk_wdata;
    mk_rdata <= mask[mk_raddr];
  end

  always_comb begin
    limit = (padding_passes > 6'(PASS_CAP)) ? 6'(PASS_CAP) : padding_passes;
    for (int i = 0; i < 3; i++) begin
      sx[i] = $signed({{(EW-DW-9){cop.dv[i][DW-1]}}, cop.dv[i], 9'h000});
      sy[i] = $signed({{(EW-DW-9){cop.du[i][DW-1]}}, cop.du[i], 9'h000});
    end
    neg = 1'b0;
    pos = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (e[i][EW-1]) neg = 1'b1;
      if (!e[i][EW-1] && e[i] != '0) pos = 1'b1;
    end
    cov = !(neg && pos);
  end

  // dilation neighbor pick over the old mask rows, first hit in raster order
  always_comb begin
    lb = (x != '0);
    rb = (x != '1);
    xl = x - 1'b1;
    xr = x + 1'b1;
    ym = y - 1'b1;
    yp = y + 1'b1;
    cand[0] = lb && prev[xl];
    cand[1] = prev[x];
    cand[2] = rb && prev[xr];
    cand[3] = lb && cur[xl];
    cand[4] = rb && cur[xr];
    cand[5] = lb && nxt[xl];
    cand[6] = nxt[x];
    cand[7] = rb && nxt[xr];
    nb_addr[0] = {ym, xl};
    nb_addr[1] = {ym, x};
    nb_addr[2] = {ym, xr};
    nb_addr[3] = {y, xl};
    nb_addr[4] = {y, xr};
    nb_addr[5] = {yp, xl};
    nb_addr[6] = {yp, x};
    nb_addr[7] = {yp, xr};
    naddr = nb_addr[7];
    for (int k = 7; k >= 0; k--) begin
      if (cand[k]) naddr = nb_addr[k];
    end
    dfill = !cur[x] && (cand != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      dpend          <= 1'b0;
      cnt            <= '0;
      clear_value    <= '0;
      padding_passes <= 6'd4;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CLEAR_VALUE:    clear_value    <= cfg_data;
          REG_PADDING_PASSES: padding_passes <= cfg_data[5:0];
          default: ;
        endcase
      end

      dpend <= (state == B_D_PIX) && dfill;

      if (state == B_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_item  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        B_INIT: begin
          cnt <= (cnt[YW-1:0] == '1) ? '0 : cnt + 1'b1;
        end
        B_IDLE: begin
          if (!empty) begin
            cop   <= op;
            x     <= op.x0;
            y     <= op.y0;
            count <= '0;
            run   <= '0;
            cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
              e[i]    <= op.e0[i];
              erow[i] <= op.e0[i];
            end
          end
        end
        B_CLR: begin
          cnt <= cnt + 1'b1;
          res <= '0;
        end
        B_P_LD: cur <= mk_rdata;
        B_P_PIX: begin
          if (cov) begin
            cur[x] <= 1'b1;
            if (!cur[x]) count <= count + 15'd1;
          end
          if (x != cop.x1) begin
            x <= x + 1'b1;
            for (int i = 0; i < 3; i++) e[i] <= e[i] + sx[i];
          end
        end
        B_P_WB: begin
          if (y != cop.y1) begin
            y <= y + 1'b1;
            x <= cop.x0;
            for (int i = 0; i < 3; i++) begin
              erow[i] <= erow[i] - sy[i];
              e[i]    <= erow[i] - sy[i];
            end
          end
        end
        B_P_CHK: begin
          res <= out_item_t'{painted_count: count, passes_run: 6'd0,
                             pixel_value: 32'd0, pixel_marked: 1'b0};
        end
        B_C_LD: begin
          // nothing new was covered: the centroid pixel alone
          res <= out_item_t'{painted_count: {14'h0000, !mk_rdata[cop.cx]},
                             passes_run: 6'd0, pixel_value: 32'd0, pixel_marked: 1'b0};
        end
        B_D_START: begin
          res <= out_item_t'{painted_count: 15'd0, passes_run: run,
                             pixel_value: 32'd0, pixel_marked: 1'b0};
          if (run < limit) begin
            run     <= run + 6'd1;
            changed <= 1'b0;
            y       <= '0;
            prev    <= '0;
            fresh   <= '0;
          end
        end
        B_D_LC: cur <= mk_rdata;
        B_D_LD: begin
          nxt <= (y == '1) ? '0 : mk_rdata;
          x   <= '0;
        end
        B_D_PIX: begin
          if (dfill) begin
            fresh[x]   <= 1'b1;
            changed    <= 1'b1;
            dpend_addr <= {y, x};
          end
          x <= x + 1'b1;
        end
        B_D_WB: begin
          prev  <= cur;
          cur   <= nxt;
          fresh <= '0;
          if (y != '1) y <= y + 1'b1;
        end
        B_D_END: begin
          res <= out_item_t'{painted_count: 15'd0, passes_run: run,
                             pixel_value: 32'd0, pixel_marked: 1'b0};
        end
        B_R_LD: begin
          res <= out_item_t'{painted_count: 15'd0, passes_run: 6'd0,
                             pixel_value: st_rdata,
                             pixel_marked: mk_rdata[cop.pix[XW-1:0]]};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_INIT: if (cnt[YW-1:0] == '1) state_next = B_IDLE;
      B_IDLE: begin
        if (!empty) begin
          case (op.cmd)
            CMD_CLEAR:  state_next = B_CLR;
            CMD_PAINT:  state_next = B_P_RD;
            CMD_DILATE: state_next = B_D_START;
            CMD_READ:   state_next = B_R_RD;
            default:    state_next = B_IDLE;
          endcase
        end
      end
      B_CLR:     if (cnt == '1) state_next = B_DONE;
      B_P_RD:    state_next = B_P_LD;
      B_P_LD:    state_next = B_P_PIX;
      B_P_PIX:   if (x == cop.x1) state_next = B_P_WB;
      B_P_WB:    state_next = (y == cop.y1) ? B_P_CHK : B_P_RD;
      B_P_CHK:   state_next = (count != '0) ? B_DONE : B_C_LD;
      B_C_LD:    state_next = B_DONE;
      B_D_START: state_next = (run < limit) ? B_D_LC : B_DONE;
      B_D_LC:    state_next = B_D_RD;
      B_D_RD:    state_next = B_D_LD;
      B_D_LD:    state_next = B_D_PIX;
      B_D_PIX:   if (x == '1) state_next = B_D_WB;
      B_D_WB:    state_next = (y == '1) ? B_D_END : B_D_RD;
      B_D_END:   state_next = changed ? B_D_START : B_DONE;
      B_R_RD:    state_next = B_R_LD;
      B_R_LD:    state_next = B_DONE;
      B_DONE:    if (!out_valid || out_ready) state_next = B_IDLE;
      default:   state_next = B_IDLE;
    endcase
  end

  always_comb begin
    st_we     = 1'b0;
    st_waddr  = {y, x};
    st_wdata  = cop.word;
    st_raddr  = naddr;
    mk_we     = 1'b0;
    mk_waddr  = y;
    mk_wdata  = cur;
    mk_raddr  = y;
    pop       = (state == B_IDLE) && !empty;
    init_busy = (state == B_INIT);
    // copy of a dilated pixel is written in the cycle after its neighbor is read
    if (dpend) begin
      st_we    = 1'b1;
      st_waddr = dpend_addr;
      st_wdata = st_rdata;
    end
    case (state)
      B_INIT: begin
        mk_we    = 1'b1;
        mk_waddr = cnt[YW-1:0];
        mk_wdata = '0;
      end
      B_CLR: begin
        st_we    = 1'b1;
        st_waddr = cnt;
        st_wdata = clear_value;
        if (cnt[AW-1:YW] == '0) begin
          mk_we    = 1'b1;
          mk_waddr = cnt[YW-1:0];
          mk_wdata = '0;
        end
      end
      B_P_PIX: st_we = cov;
      B_P_WB:  mk_we = 1'b1;
      B_P_CHK: mk_raddr = cop.cy;
      B_C_LD: begin
        st_we    = 1'b1;
        st_waddr = {cop.cy, cop.cx};
        mk_we    = 1'b1;
        mk_waddr = cop.cy;
        mk_wdata = mk_rdata | (TEX_W'(1) << cop.cx);
      end
      B_D_START: mk_raddr = '0;
      B_D_RD:    mk_raddr = y + 1'b1;
      B_D_WB: begin
        mk_we    = 1'b1;
        mk_wdata = cur | fresh;
      end
      B_R_RD: begin
        st_raddr = cop.pix;
        mk_raddr = cop.pix[AW-1:XW];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/uv_triangle_raster_and_dilate_top.sv]
// Top level of the UV triangle rasterizer: front end, command queue, engine.
// Depends on uvr_pkg, uvr_front, uvr_queue and uvr_back.
//
// One result per item. After reset the painted mask is cleared one row a cycle
// and in_ready stays low. The front end takes one item at a time; paint edge setup
// runs on one shared 21x21 multiplier. Up to two decoded items queue behind the engine.
// Engine work: clear writes one pixel store word a cycle; read fetches one pixel
// and its mask row; paint walks the clamped box row by row, with an extra step
// when the centroid fallback fires; dilate runs passes until one changes nothing
// or the pass limit is reached, with an extra limit check in the latter case,
// one pixel a cycle per pass, bound by the single read and write port of the
// pixel store. A finished result waits in the output register while the next
// item is taken.
`default_nettype none

module uv_triangle_raster_and_dilate_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire uvr_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output uvr_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import uvr_pkg::*;

  logic    push, pop, init_busy;
  op_t     push_op, head_op;
  q_stat_t qstat;

  assign cfg_ready = 1'b1;

  uvr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .hold     (init_busy),
    .push     (push),
    .push_op  (push_op),
    .full     (qstat.full)
  );

  uvr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_op),
    .pop  (pop),
    .dout (head_op),
    .stat (qstat)
  );

  uvr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (head_op),
    .empty     (qstat.empty),
    .pop       (pop),
    .init_busy (init_busy),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[sv/uvr_checker.sv]
// Port-level checks for the rasterizer top level, and the bind that attaches them.
// Depends on uvr_pkg and uv_triangle_raster_and_dilate_top.
`default_nettype none

module uvr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire uvr_pkg::out_item_t out_item
);
  import uvr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_init: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block ready before mask clear pass");

  a_pass_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.passes_run <= 6'd32)
    else $error("pass count above cap");

  a_dilate_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.passes_run != '0 |->
      out_item.painted_count == '0 && out_item.pixel_value == '0 && !out_item.pixel_marked)
    else $error("dilate result carries other fields");

  a_paint_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.painted_count != '0 |->
      out_item.painted_count <= 15'd16384 && out_item.passes_run == '0
      && out_item.pixel_value == '0 && !out_item.pixel_marked)
    else $error("paint result malformed");

endmodule

bind uv_triangle_raster_and_dilate_top uvr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for uv_triangle_raster_and_dilate_top: clear, paint, dilate, read.
// Depends on uvr_pkg and the top level; a built-in raster/dilate predictor supplies results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uvr_pkg::*;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam longint     UV_ONE      = 65536;
  localparam int         CYCLE_LIMIT = 8_000_000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  uv_triangle_raster_and_dilate_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // texture model
  logic [31:0] tex_word [NPIX];
  bit          tex_mark [NPIX];
  bit          pass_new [NPIX];
  logic [31:0] clear_word = '0;
  int unsigned pass_limit = 4;

  out_item_t   pending_results [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          mode = 0;
  int          mode_left = 0;
  logic        in_acc = 1'b0;
  logic        cfg_acc = 1'b0;

  always @(posedge clk) begin
    in_acc  <= !rst && in_valid && in_ready;
    cfg_acc <= !rst && cfg_valid && cfg_ready;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_to(input longint v, input longint hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // sign of the edge function of sample p against edge q-r
  function automatic int edge_side(input longint px, input longint py, input longint qx,
                                   input longint qy, input longint rx, input longint ry);
    longint e;
    e = (px - rx) * (qy - ry) - (qx - rx) * (py - ry);
    return (e > 0) ? 1 : ((e < 0) ? -1 : 0);
  endfunction

  function automatic int mark_pixel(input longint idx, input logic [31:0] word);
    int fresh;
    fresh = tex_mark[idx] ? 0 : 1;
    tex_word[idx] = word;
    tex_mark[idx] = 1'b1;
    return fresh;
  endfunction

  function automatic int paint_triangle(input in_item_t it);
    longint u[3], v[3], sx[3], sy[3];
    longint umin, umax, vmin, vmax, x0, x1, y0, y1, px, py, cx, cy;
    int d1, d2, d3, count;
    u[0] = longint'($signed(it.vert_a_u)); v[0] = longint'($signed(it.vert_a_v));
    u[1] = longint'($signed(it.vert_b_u)); v[1] = longint'($signed(it.vert_b_v));
    u[2] = longint'($signed(it.vert_c_u)); v[2] = longint'($signed(it.vert_c_v));
    umin = u[0]; umax = u[0]; vmin = v[0]; vmax = v[0];
    for (int i = 1; i < 3; i++) begin
      if (u[i] < umin) umin = u[i];
      if (u[i] > umax) umax = u[i];
      if (v[i] < vmin) vmin = v[i];
      if (v[i] > vmax) vmax = v[i];
    end
    x0 = clamp_to(floor_div(umin * TEX_W, UV_ONE), TEX_W - 1);
    x1 = clamp_to(floor_div(umax * TEX_W, UV_ONE), TEX_W - 1);
    y0 = clamp_to(floor_div(vmin * TEX_H, UV_ONE), TEX_H - 1);
    y1 = clamp_to(floor_div(vmax * TEX_H, UV_ONE), TEX_H - 1);
    for (int i = 0; i < 3; i++) begin
      sx[i] = u[i] * 2 * TEX_W;
      sy[i] = v[i] * 2 * TEX_H;
    end
    count = 0;
    for (longint y = y0; y <= y1; y++) begin
      for (longint x = x0; x <= x1; x++) begin
        px = (2 * x + 1) * UV_ONE;
        py = (2 * y + 1) * UV_ONE;
        d1 = edge_side(px, py, sx[0], sy[0], sx[1], sy[1]);
        d2 = edge_side(px, py, sx[1], sy[1], sx[2], sy[2]);
        d3 = edge_side(px, py, sx[2], sy[2], sx[0], sy[0]);
        if ((d1 < 0 || d2 < 0 || d3 < 0) && (d1 > 0 || d2 > 0 || d3 > 0)) continue;
        count += mark_pixel(y * TEX_W + x, it.part_word);
      end
    end
    // nothing new covered: centroid pixel instead
    if (count == 0) begin
      cx = clamp_to(floor_div((u[0] + u[1] + u[2]) * TEX_W, 3 * UV_ONE), TEX_W - 1);
      cy = clamp_to(floor_div((v[0] + v[1] + v[2]) * TEX_H, 3 * UV_ONE), TEX_H - 1);
      count += mark_pixel(cy * TEX_W + cx, it.part_word);
    end
    return count;
  endfunction

  function automatic int grow_mask();
    int unsigned lim;
    int run, nx, ny, n, idx;
    bit changed, done;
    lim = (pass_limit > PASS_CAP) ? PASS_CAP : pass_limit;
    run = 0;
    while (run < lim) begin
      changed = 1'b0;
      pass_new = '{default: 1'b0};
      run++;
      for (int y = 0; y < TEX_H; y++) begin
        for (int x = 0; x < TEX_W; x++) begin
          idx = y * TEX_W + x;
          if (tex_mark[idx]) continue;
          done = 1'b0;
          for (int dy = -1; dy <= 1 && !done; dy++) begin
            for (int dx = -1; dx <= 1 && !done; dx++) begin
              nx = x + dx;
              ny = y + dy;
              if (dx == 0 && dy == 0) continue;
              if (nx < 0 || ny < 0 || nx >= TEX_W || ny >= TEX_H) continue;
              n = ny * TEX_W + nx;
              if (tex_mark[n] && !pass_new[n]) begin
                tex_word[idx] = tex_word[n];
                tex_mark[idx] = 1'b1;
                pass_new[idx] = 1'b1;
                changed = 1'b1;
                done = 1'b1;
              end
            end
          end
        end
      end
      if (!changed) break;
    end
    return run;
  endfunction

  function automatic out_item_t raster_result(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NPIX; i++) tex_word[i] = clear_word;
        tex_mark = '{default: 1'b0};
      end
      CMD_PAINT:  r.painted_count = 15'(paint_triangle(it));
      CMD_DILATE: r.passes_run = 6'(grow_mask());
      default: begin
        r.pixel_value  = tex_word[it.pixel_index];
        r.pixel_marked = tex_mark[it.pixel_index];
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_item.painted_count !== want.painted_count)
          report($sformatf("painted_count %0d want %0d", out_item.painted_count,
                           want.painted_count));
        if (out_item.passes_run !== want.passes_run)
          report($sformatf("passes_run %0d want %0d", out_item.passes_run, want.passes_run));
        if (out_item.pixel_value !== want.pixel_value)
          report($sformatf("pixel_value %h want %h", out_item.pixel_value, want.pixel_value));
        if (out_item.pixel_marked !== want.pixel_marked)
          report($sformatf("pixel_marked %b want %b", out_item.pixel_marked,
                           want.pixel_marked));
      end
    end
  end

  // receiver: stall modes of random length, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_ready <= 1'b0;
      hold_req--;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_acc);
    pending_results.push_back(raster_result(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    drain();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
    if (idx == REG_CLEAR_VALUE) clear_word = data;
    else if (idx == REG_PADDING_PASSES) pass_limit = data[5:0];
  endtask

  function automatic in_item_t noise_item(input cmd_t c);
    in_item_t     it;
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.cmd = c;
    return it;
  endfunction

  function automatic in_item_t tri_item(input int au, input int av, input int bu, input int bv,
                                        input int cu, input int cv);
    in_item_t it;
    it = noise_item(CMD_PAINT);
    it.vert_a_u = 20'(au); it.vert_a_v = 20'(av);
    it.vert_b_u = 20'(bu); it.vert_b_v = 20'(bv);
    it.vert_c_u = 20'(cu); it.vert_c_v = 20'(cv);
    return it;
  endfunction

  function automatic in_item_t read_item(input int idx);
    in_item_t it;
    it = noise_item(CMD_READ);
    it.pixel_index = 14'(idx);
    return it;
  endfunction

  function automatic int near_val(input int base);
    return base + $urandom_range(0, 8192) - 4096;
  endfunction

  function automatic in_item_t random_tri();
    int bu, bv, k;
    k = $urandom_range(0, 19);
    if (k < 16) begin
      bu = $urandom_range(0, 65535);
      bv = $urandom_range(0, 65535);
    end else if (k < 19) begin
      bu = $urandom_range(0, 1040000) - 520000;
      bv = $urandom_range(0, 1040000) - 520000;
    end else begin
      // straddles a texture border
      bu = $urandom_range(0, 1) ? $urandom_range(0, 4096) - 2048 : $urandom_range(63488, 67584);
      bv = $urandom_range(0, 1) ? $urandom_range(0, 4096) - 2048 : $urandom_range(63488, 67584);
    end
    return tri_item(near_val(bu), near_val(bv), near_val(bu), near_val(bv),
                    near_val(bu), near_val(bv));
  endfunction

  task automatic test_registers_and_clear();
    cfg_write(REG_SPARE_2, $urandom);
    cfg_write(REG_SPARE_3, $urandom);
    cfg_write(REG_CLEAR_VALUE, 32'hFFFF_FFFF);
    send(noise_item(CMD_CLEAR));
    send(read_item(0));
    send(read_item(NPIX - 1));
    send(noise_item(CMD_DILATE));   // empty mask, one idle pass
    cfg_write(REG_CLEAR_VALUE, $urandom);
    send(noise_item(CMD_CLEAR));
    send(read_item($urandom_range(0, NPIX - 1)));
  endtask

  task automatic test_paint_cases();
    send(tri_item(5376, 10496, 5376, 10496, 5376, 10496));   // point on a sample centre
    send(read_item(20 * TEX_W + 10));
    send(tri_item(15460, 15460, 15460, 15460, 15460, 15460)); // point between centres
    send(tri_item(1000, 1000, 9000, 2000, 3000, 8000));
    send(tri_item(1000, 1000, 3000, 8000, 9000, 2000));       // opposite winding, all marked
    send(tri_item(-524288, -524288, -500000, -524288, -524288, -500000));
    send(tri_item(524287, 524287, 500000, 524287, 524287, 500000));
    send(tri_item(20000, 30000, 40000, 30000, 60000, 30000)); // zero-area line
    send(tri_item(-524288, -524288, 524287, -524288, -524288, 524287));
    send(read_item(NPIX - 1));
  endtask

  task automatic test_dilation();
    cfg_write(REG_PADDING_PASSES, 0);
    send(noise_item(CMD_DILATE));
    cfg_write(REG_CLEAR_VALUE, 0);
    send(noise_item(CMD_CLEAR));
    send(tri_item(30000, 30000, 32000, 30500, 31000, 33000));
    cfg_write(REG_PADDING_PASSES, 2);
    send(noise_item(CMD_DILATE));
    send(read_item(($urandom_range(55, 66)) * TEX_W + $urandom_range(55, 66)));
    cfg_write(REG_PADDING_PASSES, 32);
    // all but a small far corner, so growth stops well before the cap
    send(tri_item(0, 0, 129106, 0, 0, 129106));
    send(noise_item(CMD_DILATE));
    send(read_item(NPIX - 1));
  endtask

  task automatic test_output_stall();
    drain();
    hold_req = 600;
    for (int i = 0; i < 12; i++) send(read_item($urandom_range(0, NPIX - 1)));
  endtask

  task automatic test_random();
    int r;
    for (int phase = 0; phase < 8; phase++) begin
      cfg_write(REG_PADDING_PASSES, $urandom_range(0, 3));
      cfg_write(REG_CLEAR_VALUE, $urandom);
      for (int i = 0; i < 215; i++) begin
        r = $urandom_range(0, 999);
        if (r < 4) send(noise_item(CMD_CLEAR));
        else if (r < 9) send(noise_item(CMD_DILATE));
        else if (r < 350) send(read_item($urandom_range(0, NPIX - 1)));
        else send(random_tri());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_registers_and_clear();
    test_paint_cases();
    test_dilation();
    test_output_stall();
    test_random();
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

[files.f]
sv/uvr_pkg.sv
sv/uvr_front.sv
sv/uvr_queue.sv
sv/uvr_back.sv
sv/uv_triangle_raster_and_dilate_top.sv
sv/uvr_checker.sv
tb/tb.sv
